[src/abi_pkg.sv]
// ----------------------------------------------------------------------------
// abi_pkg
// Shared types, status codes and saturation helper for the arrow block inverse.
// ----------------------------------------------------------------------------
package abi_pkg;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

	localparam logic signed [67:0] QMAX = 68'sd2147483647;
	localparam logic signed [67:0] QMIN = -68'sd2147483648;

	// side band carried through the corner reciprocal
	typedef struct packed {
		logic             szero;
		logic             sat;
		logic signed [31:0] q;
		logic [2:0][31:0] d;
		logic [2:0][31:0] g;
		logic [2:0][31:0] l;
	} side_a_t;

	// one row of the arrow: top row entry and left column entry
	typedef struct packed {
		logic signed [31:0] d;
		logic signed [31:0] g;
	} lane_t;

	// side band carried through the first diagonal reciprocal
	typedef struct packed {
		logic               zero;
		logic               sat;
		logic signed [31:0] is;
		lane_t              lane;
	} side_b_t;

	// clamp to signed 32 bits; bit 32 flags a clamp
	function automatic logic [32:0] sat32(input logic signed [67:0] x);
		if (x > QMAX) begin
			return {1'b1, 32'h7fff_ffff};
		end else if (x < QMIN) begin
			return {1'b1, 32'h8000_0000};
		end else begin
			return {1'b0, x[31:0]};
		end
	endfunction

endpackage

[src/abi_recip.sv]
// ----------------------------------------------------------------------------
// abi_recip
// Pipelined reciprocal 2^N / den, one quotient bit per stage, truncated
// toward zero and clamped to signed 32 bits. Side band travels alongside.
// ----------------------------------------------------------------------------
module abi_recip #(
	parameter int N      = 32,
	parameter int SIDE_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic signed [31:0]  den,
	input  logic [SIDE_W-1:0]   side_in,
	output logic                out_valid,
	output logic signed [31:0]  quot,
	output logic                quot_sat,
	output logic [SIDE_W-1:0]   side_out
);
	import abi_pkg::*;

	localparam int STEPS = N + 1;

	logic              v_s    [0:STEPS];
	logic [31:0]       rem_s  [0:STEPS];
	logic [N:0]        quo_s  [0:STEPS];
	logic [31:0]       mag_s  [0:STEPS];
	logic              neg_s  [0:STEPS];
	logic [SIDE_W-1:0] side_s [0:STEPS];

	logic [32:0] trial [0:STEPS-1];
	logic        ge    [0:STEPS-1];
	logic [32:0] den_neg;
	logic [63:0] qx;

	logic              v_q;
	logic signed [31:0] quot_q;
	logic              sat_q;
	logic [SIDE_W-1:0] side_q;

	assign den_neg = -{den[31], den};

	always_comb begin
		for (int k = 0; k < STEPS; k++) begin
			trial[k] = {rem_s[k], (k == 0)};
			ge[k]    = trial[k] >= {1'b0, mag_s[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= STEPS; k++) v_s[k] <= 1'b0;
			v_q <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int k = 0; k < STEPS; k++) v_s[k+1] <= v_s[k];
			v_q <= v_s[STEPS];
		end
	end

	assign qx = 64'(quo_s[STEPS]);

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s[0]  <= den[31] ? den_neg[31:0] : den;
			neg_s[0]  <= den[31];
			rem_s[0]  <= '0;
			quo_s[0]  <= '0;
			side_s[0] <= side_in;
			for (int k = 0; k < STEPS; k++) begin
				rem_s[k+1]  <= ge[k] ? 32'(trial[k] - {1'b0, mag_s[k]}) : trial[k][31:0];
				quo_s[k+1]  <= {quo_s[k][N-1:0], ge[k]};
				mag_s[k+1]  <= mag_s[k];
				neg_s[k+1]  <= neg_s[k];
				side_s[k+1] <= side_s[k];
			end
			// apply sign and clamp
			if (neg_s[STEPS]) begin
				sat_q  <= qx > 64'h8000_0000;
				quot_q <= (qx > 64'h8000_0000) ? 32'h8000_0000 : 32'(-qx);
			end else begin
				sat_q  <= qx > 64'h7fff_ffff;
				quot_q <= (qx > 64'h7fff_ffff) ? 32'h7fff_ffff : qx[31:0];
			end
			side_q <= side_s[STEPS];
		end
	end

	assign out_valid = v_q;
	assign quot      = quot_q;
	assign quot_sat  = sat_q;
	assign side_out  = side_q;

endmodule

[src/arrow_block_inverse_unit.sv]
// ----------------------------------------------------------------------------
// arrow_block_inverse_unit
// Inverse of a 4x4 arrow-shaped block through the Schur complement.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_ready) takes one word: corner, top row
//    row_x..z, left column col_x..z and diagonal diag_x..z, signed fixed point
//    with FRAC_BITS fraction bits.
//  - Output channel (out_valid / out_ready) gives one word per input word:
//    the inverse in the same shape plus status (ok, zero divisor, saturated).
//  - Throughput: one word per cycle, sustained, while the receiver takes.
//  - Pipeline: two pipelined restoring dividers, one quotient bit per stage
//    each: 2*FRAC_BITS + 3 stages for 1/corner, then the same for the three
//    diagonal reciprocals in parallel; multiplies, rounding and clamps fill
//    the rest, one multiplier or one add and clamp per stage.
//  - Stall: when the last stage holds a word that is not taken, the whole
//    pipeline holds; in_ready drops in that cycle. Nothing is dropped.
//  - Reset (arst_n low) clears every valid bit; payload registers are not
//    cleared. The block takes words as soon as reset is released.
//  - A zero corner or a zero Schur term gives status zero divisor and all
//    entries zero; otherwise any clamp on the way gives status saturated.
// ----------------------------------------------------------------------------
module arrow_block_inverse_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] corner,
	input  logic signed [31:0] row_x,
	input  logic signed [31:0] row_y,
	input  logic signed [31:0] row_z,
	input  logic signed [31:0] col_x,
	input  logic signed [31:0] col_y,
	input  logic signed [31:0] col_z,
	input  logic signed [31:0] diag_x,
	input  logic signed [31:0] diag_y,
	input  logic signed [31:0] diag_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] inv_corner,
	output logic signed [31:0] inv_row_x,
	output logic signed [31:0] inv_row_y,
	output logic signed [31:0] inv_row_z,
	output logic signed [31:0] inv_col_x,
	output logic signed [31:0] inv_col_y,
	output logic signed [31:0] inv_col_z,
	output logic signed [31:0] inv_diag_x,
	output logic signed [31:0] inv_diag_y,
	output logic signed [31:0] inv_diag_z,
	output logic [1:0]         status
);
	import abi_pkg::*;

	localparam int RN = 2 * FRAC_BITS;

	// floor shift of an exact product
	function automatic logic signed [67:0] shr(input logic signed [67:0] x);
		return x >>> FRAC_BITS;
	endfunction

	logic en;
	logic signed [31:0] din [3];
	logic signed [31:0] gin [3];
	logic signed [31:0] lin [3];

	// stage 1: products g*d
	logic v_s1;
	logic signed [31:0] c_s1;
	logic signed [31:0] d_s1 [3];
	logic signed [31:0] g_s1 [3];
	logic signed [31:0] l_s1 [3];
	logic signed [63:0] p_s1 [3];

	// stage 2: q
	logic v_s2;
	logic [32:0] q_sat;
	side_a_t side_a_in;
	logic signed [31:0] c_s2;

	// corner reciprocal
	logic va;
	logic signed [31:0] is_a;
	logic is_sat_a;
	side_a_t side_a;

	// stage 3..5: q*is, clamp, Schur terms
	logic v_s3, v_s4, v_s5;
	logic signed [63:0] tp_s3;
	logic signed [31:0] t_s4;
	logic signed [31:0] is_s3, is_s4, is_s5;
	logic sat_s3, sat_s4, sat_s5;
	logic zero_s3, zero_s4, zero_s5;
	logic [2:0][31:0] d_s3, g_s3, l_s3, d_s4, g_s4, l_s4, d_s5, g_s5;
	logic signed [31:0] schur_s5 [3];
	logic [32:0] t_sat;
	logic [32:0] sc_sat [3];

	// diagonal reciprocals
	side_b_t side_b_in;
	side_b_t side_b;
	lane_t lane1_in, lane2_in, lane1, lane2;
	logic vb [3];
	logic signed [31:0] nl_b [3];
	logic nl_sat_b [3];
	lane_t lane_b [3];

	// stages 6..13
	logic v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12, v_s13;
	logic zero_s6, zero_s7, zero_s8, zero_s9, zero_s10, zero_s11, zero_s12, zero_s13;
	logic sat_s6, sat_s7, sat_s8, sat_s9, sat_s10, sat_s11, sat_s12, sat_s13;
	logic signed [31:0] is_s6, is_s7, is_s8, is_s9, is_s10, is_s11;
	logic signed [31:0] nl_s6 [3], nl_s7 [3], nl_s8 [3], nl_s9 [3];
	logic signed [31:0] nl_s10 [3], nl_s11 [3], nl_s12 [3], nl_s13 [3];
	logic signed [31:0] d_s6 [3], g_s6 [3], d_s7 [3], g_s7 [3];
	logic signed [31:0] d_s8 [3], d_s9 [3];
	logic signed [65:0] hp_s6 [3];
	logic signed [31:0] h_s7 [3];
	logic signed [63:0] gp_s8 [3], dp_s8 [3];
	logic signed [31:0] ng_s9 [3], nd_s9 [3];
	logic signed [31:0] ng_s10 [3], nd_s10 [3], ng_s11 [3], nd_s11 [3];
	logic signed [31:0] ng_s12 [3], nd_s12 [3], ng_s13 [3], nd_s13 [3];
	logic signed [63:0] ap_s10 [3];
	logic signed [31:0] acc_s11;
	logic signed [63:0] ep_s12;
	logic signed [31:0] ns_s13;
	logic [32:0] h_sat [3], ng_sat [3], nd_sat [3];
	logic [32:0] acc_sat, ns_sat;
	logic [32:0] nl_neg [3];
	logic signed [67:0] acc_sum;

	// advance the whole pipe unless a finished word waits
	assign en       = !v_s13 || out_ready;
	assign in_ready = en;

	assign din = '{row_x, row_y, row_z};
	assign gin = '{col_x, col_y, col_z};
	assign lin = '{diag_x, diag_y, diag_z};

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0; v_s10 <= 1'b0;
			v_s11 <= 1'b0; v_s12 <= 1'b0; v_s13 <= 1'b0;
		end else if (en) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= va;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= vb[0] & vb[1] & vb[2];
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
		end
	end

	// stage 1
	always_ff @(posedge clk) begin
		if (en) begin
			c_s1 <= corner;
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= din[i];
				g_s1[i] <= gin[i];
				l_s1[i] <= lin[i];
				p_s1[i] <= 64'(gin[i]) * 64'(din[i]);
			end
		end
	end

	// stage 2: q = sum of shifted products
	assign q_sat = sat32(shr(68'(p_s1[0])) + shr(68'(p_s1[1])) + shr(68'(p_s1[2])));

	always_ff @(posedge clk) begin
		if (en) begin
			c_s2            <= c_s1;
			side_a_in.szero <= c_s1 == 32'sd0;
			side_a_in.sat   <= q_sat[32];
			side_a_in.q     <= q_sat[31:0];
			for (int i = 0; i < 3; i++) begin
				side_a_in.d[i] <= d_s1[i];
				side_a_in.g[i] <= g_s1[i];
				side_a_in.l[i] <= l_s1[i];
			end
		end
	end

	abi_recip #(.N(RN), .SIDE_W($bits(side_a_t))) u_recip_corner (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s2),
		.den      (c_s2),
		.side_in  (side_a_in),
		.out_valid(va),
		.quot     (is_a),
		.quot_sat (is_sat_a),
		.side_out (side_a)
	);

	// stages 3..5
	assign t_sat = sat32(shr(68'(tp_s3)));
	always_comb begin
		for (int i = 0; i < 3; i++) sc_sat[i] = sat32(68'($signed(l_s4[i])) - 68'(t_s4));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tp_s3   <= 64'(side_a.q) * 64'(is_a);
			is_s3   <= is_a;
			sat_s3  <= side_a.sat | is_sat_a;
			zero_s3 <= side_a.szero;
			d_s3    <= side_a.d;
			g_s3    <= side_a.g;
			l_s3    <= side_a.l;

			t_s4    <= t_sat[31:0];
			is_s4   <= is_s3;
			sat_s4  <= sat_s3 | t_sat[32];
			zero_s4 <= zero_s3;
			d_s4    <= d_s3;
			g_s4    <= g_s3;
			l_s4    <= l_s3;

			is_s5   <= is_s4;
			d_s5    <= d_s4;
			g_s5    <= g_s4;
			sat_s5  <= sat_s4 | sc_sat[0][32] | sc_sat[1][32] | sc_sat[2][32];
			zero_s5 <= zero_s4 || sc_sat[0][31:0] == 32'd0 || sc_sat[1][31:0] == 32'd0
				|| sc_sat[2][31:0] == 32'd0;
			for (int i = 0; i < 3; i++) schur_s5[i] <= sc_sat[i][31:0];
		end
	end

	// diagonal reciprocals, lane 0 carries the shared side band
	assign side_b_in.zero   = zero_s5;
	assign side_b_in.sat    = sat_s5;
	assign side_b_in.is     = is_s5;
	assign side_b_in.lane.d = d_s5[0];
	assign side_b_in.lane.g = g_s5[0];
	assign lane1_in.d = d_s5[1];
	assign lane1_in.g = g_s5[1];
	assign lane2_in.d = d_s5[2];
	assign lane2_in.g = g_s5[2];

	abi_recip #(.N(RN), .SIDE_W($bits(side_b_t))) u_recip_diag0 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s5), .den(schur_s5[0]),
		.side_in(side_b_in), .out_valid(vb[0]), .quot(nl_b[0]), .quot_sat(nl_sat_b[0]),
		.side_out(side_b)
	);
	abi_recip #(.N(RN), .SIDE_W($bits(lane_t))) u_recip_diag1 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s5), .den(schur_s5[1]),
		.side_in(lane1_in), .out_valid(vb[1]), .quot(nl_b[1]), .quot_sat(nl_sat_b[1]),
		.side_out(lane1)
	);
	abi_recip #(.N(RN), .SIDE_W($bits(lane_t))) u_recip_diag2 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s5), .den(schur_s5[2]),
		.side_in(lane2_in), .out_valid(vb[2]), .quot(nl_b[2]), .quot_sat(nl_sat_b[2]),
		.side_out(lane2)
	);

	assign lane_b[0] = side_b.lane;
	assign lane_b[1] = lane1;
	assign lane_b[2] = lane2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nl_neg[i] = -{nl_b[i][31], nl_b[i]};
			h_sat[i]  = sat32(shr(68'(hp_s6[i])));
			ng_sat[i] = sat32(shr(68'(gp_s8[i])));
			nd_sat[i] = sat32(shr(68'(dp_s8[i])));
		end
		acc_sum = (68'sd1 <<< FRAC_BITS) - shr(68'(ap_s10[0])) - shr(68'(ap_s10[1]))
			- shr(68'(ap_s10[2]));
	end
	assign acc_sat = sat32(acc_sum);
	assign ns_sat  = sat32(shr(68'(ep_s12)));

	// stages 6..13
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s6 <= side_b.zero;
			sat_s6  <= side_b.sat | nl_sat_b[0] | nl_sat_b[1] | nl_sat_b[2];
			is_s6   <= side_b.is;
			for (int i = 0; i < 3; i++) begin
				hp_s6[i] <= 66'($signed(nl_neg[i])) * 66'(side_b.is);
				nl_s6[i] <= nl_b[i];
				d_s6[i]  <= lane_b[i].d;
				g_s6[i]  <= lane_b[i].g;
			end

			zero_s7 <= zero_s6;
			sat_s7  <= sat_s6 | h_sat[0][32] | h_sat[1][32] | h_sat[2][32];
			is_s7   <= is_s6;
			zero_s8 <= zero_s7;
			sat_s8  <= sat_s7;
			is_s8   <= is_s7;
			zero_s9 <= zero_s8;
			sat_s9  <= sat_s8 | ng_sat[0][32] | ng_sat[1][32] | ng_sat[2][32]
				| nd_sat[0][32] | nd_sat[1][32] | nd_sat[2][32];
			is_s9   <= is_s8;
			zero_s10 <= zero_s9;
			sat_s10  <= sat_s9;
			is_s10   <= is_s9;
			zero_s11 <= zero_s10;
			sat_s11  <= sat_s10 | acc_sat[32];
			is_s11   <= is_s10;
			acc_s11  <= acc_sat[31:0];
			zero_s12 <= zero_s11;
			sat_s12  <= sat_s11;
			ep_s12   <= 64'(acc_s11) * 64'(is_s11);
			zero_s13 <= zero_s12;
			sat_s13  <= sat_s12 | ns_sat[32];
			ns_s13   <= ns_sat[31:0];

			for (int i = 0; i < 3; i++) begin
				h_s7[i]   <= h_sat[i][31:0];
				nl_s7[i]  <= nl_s6[i];
				d_s7[i]   <= d_s6[i];
				g_s7[i]   <= g_s6[i];

				gp_s8[i]  <= 64'(g_s7[i]) * 64'(h_s7[i]);
				dp_s8[i]  <= 64'(d_s7[i]) * 64'(h_s7[i]);
				nl_s8[i]  <= nl_s7[i];
				d_s8[i]   <= d_s7[i];

				ng_s9[i]  <= ng_sat[i][31:0];
				nd_s9[i]  <= nd_sat[i][31:0];
				nl_s9[i]  <= nl_s8[i];
				d_s9[i]   <= d_s8[i];

				ap_s10[i] <= 64'(d_s9[i]) * 64'(ng_s9[i]);
				ng_s10[i] <= ng_s9[i];
				nd_s10[i] <= nd_s9[i];
				nl_s10[i] <= nl_s9[i];

				ng_s11[i] <= ng_s10[i];
				nd_s11[i] <= nd_s10[i];
				nl_s11[i] <= nl_s10[i];
				ng_s12[i] <= ng_s11[i];
				nd_s12[i] <= nd_s11[i];
				nl_s12[i] <= nl_s11[i];
				ng_s13[i] <= ng_s12[i];
				nd_s13[i] <= nd_s12[i];
				nl_s13[i] <= nl_s12[i];
			end
		end
	end

	// drop all entries on a zero divisor
	assign out_valid  = v_s13;
	assign inv_corner = zero_s13 ? 32'sd0 : ns_s13;
	assign inv_row_x  = zero_s13 ? 32'sd0 : nd_s13[0];
	assign inv_row_y  = zero_s13 ? 32'sd0 : nd_s13[1];
	assign inv_row_z  = zero_s13 ? 32'sd0 : nd_s13[2];
	assign inv_col_x  = zero_s13 ? 32'sd0 : ng_s13[0];
	assign inv_col_y  = zero_s13 ? 32'sd0 : ng_s13[1];
	assign inv_col_z  = zero_s13 ? 32'sd0 : ng_s13[2];
	assign inv_diag_x = zero_s13 ? 32'sd0 : nl_s13[0];
	assign inv_diag_y = zero_s13 ? 32'sd0 : nl_s13[1];
	assign inv_diag_z = zero_s13 ? 32'sd0 : nl_s13[2];
	assign status     = zero_s13 ? ST_ZERO : (sat_s13 ? ST_SAT : ST_OK);

endmodule

[src/abi_checker.sv]
// ----------------------------------------------------------------------------
// abi_checker
// Port-level checks for the arrow block inverse unit.
// ----------------------------------------------------------------------------
module abi_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] inv_corner,
	input logic signed [31:0] inv_row_x,
	input logic signed [31:0] inv_col_x,
	input logic signed [31:0] inv_diag_x,
	input logic [1:0]         status
);
	import abi_pkg::*;

	// hold a stalled word
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(inv_corner) && $stable(status))
		else $error("stalled output word changed");

	// an empty output stage never blocks the input
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// a stall at the output stops the input in the same cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken during output stall");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == ST_OK || status == ST_ZERO || status == ST_SAT)
		else $error("undefined status code");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_ZERO |-> inv_corner == 32'sd0 && inv_row_x == 32'sd0
			&& inv_col_x == 32'sd0 && inv_diag_x == 32'sd0)
		else $error("zero divisor word carries entries");

endmodule

bind arrow_block_inverse_unit abi_checker u_abi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.inv_corner(inv_corner),
	.inv_row_x (inv_row_x),
	.inv_col_x (inv_col_x),
	.inv_diag_x(inv_diag_x),
	.status    (status)
);
